// ===== hw/rtl/jtae_pkg.sv =====
// ----------------------------------------------------------------------------
// jtae_pkg
// Shared types, result codes and key tables for the title/abstract extractor.
// ----------------------------------------------------------------------------
package jtae_pkg;

    // default sizing
    localparam int MAX_ARTICLES_DEF   = 8;
    localparam int TITLE_LIMIT_DEF    = 128;
    localparam int ABSTRACT_LIMIT_DEF = 256;

    // results one byte can cause at most
    localparam int MAX_RESULTS = 3;

    // key matcher position width
    localparam int MATCH_W = 4;

    // result kinds
    localparam logic [1:0] KIND_CHAR    = 2'd0;
    localparam logic [1:0] KIND_DONE    = 2'd1;
    localparam logic [1:0] KIND_ABORT   = 2'd2;
    localparam logic [1:0] KIND_SUMMARY = 2'd3;

    // special bytes
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;

    // key lengths including both quotes
    localparam logic [MATCH_W-1:0] TITLE_KEY_LEN    = 4'd7;
    localparam logic [MATCH_W-1:0] ABSTRACT_KEY_LEN = 4'd10;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_buffer;
    } in_beat_t;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [7:0] char_code;
        logic       is_abstract;
        logic [2:0] article_index;
        logic [3:0] article_count;
        logic       last_of_run;
    } out_beat_t;

    // all results of one byte
    typedef struct packed {
        out_beat_t [MAX_RESULTS-1:0] beat;
        logic [1:0]                  count;
    } step_t;

    // byte expected at a key position
    function automatic logic [7:0] key_char(input logic is_abs, input logic [MATCH_W-1:0] pos);
        logic [7:0] ch;
        ch = CH_QUOTE;
        if (!is_abs)
        begin
            case (pos)
                4'd1:    ch = "t";
                4'd2:    ch = "i";
                4'd3:    ch = "t";
                4'd4:    ch = "l";
                4'd5:    ch = "e";
                default: ch = CH_QUOTE;
            endcase
        end
        else
        begin
            case (pos)
                4'd1:    ch = "a";
                4'd2:    ch = "b";
                4'd3:    ch = "s";
                4'd4:    ch = "t";
                4'd5:    ch = "r";
                4'd6:    ch = "a";
                4'd7:    ch = "c";
                4'd8:    ch = "t";
                default: ch = CH_QUOTE;
            endcase
        end
        return ch;
    endfunction

    function automatic logic is_alnum(input logic [7:0] b);
        return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || (b >= "0" && b <= "9");
    endfunction

    function automatic logic is_ws(input logic [7:0] b);
        return b == CH_SPACE || b == CH_LF || b == CH_TAB || b == CH_CR;
    endfunction

endpackage

// ===== hw/rtl/jtae_parser.sv =====
// ----------------------------------------------------------------------------
// jtae_parser
// Parse state and per-byte step: key match, colon/skip/copy, text cleaning.
// ----------------------------------------------------------------------------
module jtae_parser #(
    parameter int MAX_ARTICLES   = jtae_pkg::MAX_ARTICLES_DEF,
    parameter int TITLE_LIMIT    = jtae_pkg::TITLE_LIMIT_DEF,
    parameter int ABSTRACT_LIMIT = jtae_pkg::ABSTRACT_LIMIT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  jtae_pkg::in_beat_t in_beat,
    output jtae_pkg::step_t    step
);
    import jtae_pkg::*;

    localparam int MAX_LIMIT = (ABSTRACT_LIMIT > TITLE_LIMIT) ? ABSTRACT_LIMIT : TITLE_LIMIT;
    localparam int LEN_W     = $clog2(MAX_LIMIT);
    localparam int CNT_W     = $clog2(MAX_ARTICLES + 1);

    typedef enum logic [8:0] {
        ST_TKEY   = 9'b000000001,
        ST_TCOLON = 9'b000000010,
        ST_TSKIP  = 9'b000000100,
        ST_TCOPY  = 9'b000001000,
        ST_AKEY   = 9'b000010000,
        ST_ACOLON = 9'b000100000,
        ST_ASKIP  = 9'b001000000,
        ST_ACOPY  = 9'b010000000,
        ST_STOP   = 9'b100000000
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [MATCH_W-1:0] match_reg, match_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic               lead_reg, lead_next;
    logic               space_reg, space_next;
    logic [CNT_W-1:0]   done_reg, done_next;

    function automatic out_beat_t mk(input logic [1:0] kind, input logic [7:0] ch,
                                     input logic is_abs, input logic [CNT_W-1:0] idx,
                                     input logic [CNT_W-1:0] cnt);
        out_beat_t r;
        r.result_kind   = kind;
        r.char_code     = ch;
        r.is_abstract   = is_abs;
        r.article_index = 3'(idx);
        r.article_count = 4'(cnt);
        r.last_of_run   = 1'b0;
        return r;
    endfunction

    // next state and results of the held byte
    always_comb
    begin
        logic [7:0]         b;
        logic               abs;
        logic               chars;
        logic [1:0]         n;
        logic [MATCH_W-1:0] mp;
        logic [MATCH_W-1:0] klen;
        logic [LEN_W-1:0]   lim;
        logic               is_skip;

        b          = in_beat.in_byte;
        phase_next = phase_reg;
        match_next = match_reg;
        len_next   = len_reg;
        lead_next  = lead_reg;
        space_next = space_reg;
        done_next  = done_reg;
        step       = '0;
        chars      = 1'b0;
        n          = 2'd0;
        abs        = (phase_reg == ST_AKEY) || (phase_reg == ST_ACOLON) ||
                     (phase_reg == ST_ASKIP) || (phase_reg == ST_ACOPY);
        mp         = '0;
        klen       = abs ? ABSTRACT_KEY_LEN : TITLE_KEY_LEN;
        lim        = abs ? LEN_W'(ABSTRACT_LIMIT - 1) : LEN_W'(TITLE_LIMIT - 1);
        is_skip    = (phase_reg == ST_TSKIP) || (phase_reg == ST_ASKIP);

        unique case (phase_reg)
            ST_TKEY, ST_AKEY:
            begin
                mp = (match_reg >= klen) ? '0 : match_reg;
                if (b == key_char(abs, mp))
                    mp = mp + 4'd1;
                else
                    mp = (b == CH_QUOTE) ? 4'd1 : 4'd0;
                if (mp == klen)
                begin
                    mp         = '0;
                    phase_next = abs ? ST_ACOLON : ST_TCOLON;
                end
                match_next = mp;
            end
            ST_TCOLON, ST_ACOLON:
            begin
                if (b == CH_COLON)
                    phase_next = abs ? ST_ASKIP : ST_TSKIP;
            end
            ST_TSKIP, ST_ASKIP, ST_TCOPY, ST_ACOPY:
            begin
                if (is_skip && (b == CH_SPACE || b == CH_QUOTE))
                begin
                    // still skipping value lead-in
                end
                else if (!is_skip && b == CH_QUOTE)
                begin
                    // closing quote ends the field and opens the next key
                    step.beat[n] = mk(KIND_DONE, 8'd0, abs, done_reg, '0);
                    n            = n + 2'd1;
                    len_next     = '0;
                    lead_next    = 1'b1;
                    space_next   = 1'b0;
                    match_next   = 4'd1;
                    if (!abs)
                        phase_next = ST_AKEY;
                    else
                    begin
                        if (done_reg < CNT_W'(MAX_ARTICLES))
                            done_next = done_reg + 1'b1;
                        phase_next = (done_next >= CNT_W'(MAX_ARTICLES)) ? ST_STOP : ST_TKEY;
                    end
                end
                else
                begin
                    phase_next = abs ? ST_ACOPY : ST_TCOPY;
                    if (len_reg < lim)
                    begin
                        len_next = len_reg + 1'b1;
                        if (lead_reg && b == CH_SPACE)
                        begin
                            // leading space dropped
                        end
                        else
                        begin
                            lead_next = 1'b0;
                            if (is_alnum(b))
                            begin
                                if (space_reg)
                                begin
                                    step.beat[n] = mk(KIND_CHAR, CH_SPACE, abs, done_reg, '0);
                                    n            = n + 2'd1;
                                end
                                step.beat[n] = mk(KIND_CHAR, b, abs, done_reg, '0);
                                n            = n + 2'd1;
                                space_next   = 1'b0;
                                chars        = 1'b1;
                            end
                            else if (is_ws(b))
                                space_next = 1'b1;
                        end
                    end
                end
            end
            ST_STOP:
            begin
                // article limit reached, bytes ignored
            end
            default:
            begin
                phase_next = ST_TKEY;
            end
        endcase

        // end of buffer: abort an open field, then summary and restart
        if (in_beat.end_of_buffer)
        begin
            if (phase_next != ST_TKEY && phase_next != ST_STOP)
            begin
                if (chars)
                    n = 2'd0;
                step.beat[n] = mk(KIND_ABORT, 8'd0,
                                  (phase_next == ST_AKEY) || (phase_next == ST_ACOLON) ||
                                  (phase_next == ST_ASKIP) || (phase_next == ST_ACOPY),
                                  done_next, '0);
                n            = n + 2'd1;
            end
            step.beat[n] = mk(KIND_SUMMARY, 8'd0, 1'b0, '0, done_next);
            n            = n + 2'd1;
            phase_next   = ST_TKEY;
            match_next   = '0;
            len_next     = '0;
            lead_next    = 1'b1;
            space_next   = 1'b0;
            done_next    = '0;
        end

        if (n != 2'd0)
            step.beat[n - 2'd1].last_of_run = 1'b1;
        step.count = n;
    end

    // parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ST_TKEY;
            match_reg <= '0;
            len_reg   <= '0;
            lead_reg  <= 1'b1;
            space_reg <= 1'b0;
            done_reg  <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            match_reg <= match_next;
            len_reg   <= len_next;
            lead_reg  <= lead_next;
            space_reg <= space_next;
            done_reg  <= done_next;
        end
    end

endmodule

// ===== hw/rtl/json_title_abstract_extractor.sv =====
// ----------------------------------------------------------------------------
// json_title_abstract_extractor
// Streams title and abstract text out of a raw JSON-like byte buffer.
// ----------------------------------------------------------------------------
// Path: a byte is held in the input register, its results in the result buffer.
// Throughput: one byte per cycle while each byte causes at most one result and
// out_ready is high; a byte causing more holds the input until the three-entry
// result buffer, draining one beat a cycle while out_ready is high, is down to
// its last beat. Reset: rst_n clears parse state, counters and buffer valid
// state at once; no clearing pass, the block takes bytes once reset is released.
module json_title_abstract_extractor #(
    parameter int MAX_ARTICLES   = jtae_pkg::MAX_ARTICLES_DEF,
    parameter int TITLE_LIMIT    = jtae_pkg::TITLE_LIMIT_DEF,
    parameter int ABSTRACT_LIMIT = jtae_pkg::ABSTRACT_LIMIT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  jtae_pkg::in_beat_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output jtae_pkg::out_beat_t out_data
);
    import jtae_pkg::*;

    logic      in_valid_reg;
    in_beat_t  in_data_reg;
    out_beat_t [MAX_RESULTS-1:0] buf_reg;
    logic [1:0] cnt_reg;
    logic       advance;
    logic       pop;
    step_t      step;

    // handshake
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = buf_reg[0];
    assign pop       = out_valid && out_ready;
    assign advance   = in_valid_reg && ((cnt_reg == 2'd0) || (cnt_reg == 2'd1 && pop));
    assign in_ready  = !in_valid_reg || advance;

    jtae_parser #(
        .MAX_ARTICLES   (MAX_ARTICLES),
        .TITLE_LIMIT    (TITLE_LIMIT),
        .ABSTRACT_LIMIT (ABSTRACT_LIMIT)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .in_beat (in_data_reg),
        .step    (step)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_data_reg <= in_data;
    end

    // result buffer count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else if (advance && step.count != 2'd0)
            cnt_reg <= step.count;
        else if (pop)
            cnt_reg <= cnt_reg - 2'd1;
    end

    // result buffer payload, head beat in slot 0
    always_ff @(posedge clk)
    begin
        if (advance && step.count != 2'd0)
            buf_reg <= step.beat;
        else if (pop)
        begin
            buf_reg[0] <= buf_reg[1];
            buf_reg[1] <= buf_reg[2];
        end
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives raw buffers into the title/abstract extractor byte by byte and
// checks every result beat against a cycle-free model of the parser.
// A short table walks the special cases first. Random buffers of well-formed,
// cut-off and noise records follow. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module testbench;
    import jtae_pkg::*;

    localparam int ARTICLE_CAP     = MAX_ARTICLES_DEF;
    localparam int TITLE_BYTES     = TITLE_LIMIT_DEF;
    localparam int ABSTRACT_BYTES  = ABSTRACT_LIMIT_DEF;
    localparam int RANDOM_RECORDS  = 12;
    localparam int STUCK_LIMIT     = 3000;
    localparam int TAIL_CYCLES     = 12;
    localparam int REPORT_LIMIT    = 10;
    localparam int NO_TYPED_COUNT  = -1;
    // table stand-in for the zero byte, which a string cannot hold
    localparam logic [7:0] ZERO_STAND_IN = 8'h01;

    localparam logic [55:0] TITLE_KEY    = "\"title\"";
    localparam logic [79:0] ABSTRACT_KEY = "\"abstract\"";

    typedef enum logic [1:0] {STG_KEY, STG_COLON, STG_SKIP, STG_COPY} parse_stage_t;
    typedef enum logic [1:0] {CLS_WORD, CLS_BLANK, CLS_OTHER} char_class_t;
    typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_style_t;

    typedef struct {
        string text;
        int    reps;
        bit    eob;
        int    want_count;
    } dir_row_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_beat_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_beat_t out_data;

    // parser model state
    parse_stage_t stage = STG_KEY;
    logic         in_abstract = 1'b0;
    logic         halted = 1'b0;
    logic [3:0]   key_pos = '0;
    logic [8:0]   value_len = '0;
    logic         at_value_start = 1'b1;
    logic         gap_pending = 1'b0;
    logic [3:0]   articles_seen = '0;

    out_beat_t  expected_beats[$];
    int         typed_summary_counts[$];
    logic [7:0] buffer_bytes[$];

    int  fail_count = 0;
    int  beats_checked = 0;
    int  bytes_accepted = 0;
    int  fields_done = 0;
    int  fields_aborted = 0;
    int  buffers_closed = 0;
    int  capped_buffers = 0;
    int  stuck_cycles = 0;
    int  burst_left = 0;
    bit  steady_tx = 1'b0;

    rx_style_t  rx_mode = RX_FREE;
    int         rx_hold = 0;
    logic [7:0] rx_tick = '0;

    // directed cases, one buffer fragment per row
    dir_row_t directed_plan [13] = '{
        '{"\001\377",                           1, 1'b1,  0},  // byte extremes, empty buffer
        '{"{\"title\": \"Deep  Nets-1\", ",      1, 1'b0, NO_TYPED_COUNT},
        '{"\"abstract\":\"\tFast\r\nand  ok!  \"}", 1, 1'b1,  1},  // tab opens the value
        '{"\"\"tit\"title\" x; : \"A1\"",        1, 1'b0, NO_TYPED_COUNT},  // key restarts
        '{"abstract\":\"B2\"",                  1, 1'b1,  1},  // closing quote opens next key
        '{"\"title\":\"Ab\"",                   1, 1'b1,  0},  // done, abort, summary at once
        '{"\"title\":\"abc",                    1, 1'b1,  0},  // end mid copy drops chars
        '{"\"title\":",                         1, 1'b1,  0},  // end in skip
        '{"\"title\":\"",                       1, 1'b0, NO_TYPED_COUNT},
        '{"ab cd ",                            30, 1'b0, NO_TYPED_COUNT},  // past title limit
        '{"\"\"abstract\":\"",                  1, 1'b0, NO_TYPED_COUNT},
        '{"w\t",                              150, 1'b0, NO_TYPED_COUNT},  // past abstract limit
        '{"\"",                                 1, 1'b1,  1}
    };

    json_title_abstract_extractor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // parser model
    // ------------------------------------------------------------------

    function automatic logic [7:0] key_byte(input logic want_abstract, input logic [3:0] pos);
        if (want_abstract)
            return ABSTRACT_KEY[(9 - pos) * 8 +: 8];
        return TITLE_KEY[(6 - pos) * 8 +: 8];
    endfunction

    function automatic char_class_t classify(input logic [7:0] b);
        if ((b >= "0" && b <= "9") || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z"))
            return CLS_WORD;
        if (b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR)
            return CLS_BLANK;
        return CLS_OTHER;
    endfunction

    function automatic out_beat_t make_beat(input logic [1:0] kind, input logic [7:0] ch,
                                            input logic field_abs, input logic [3:0] done_cnt,
                                            input logic [3:0] count);
        out_beat_t beat;
        beat = '0;
        beat.result_kind   = kind;
        beat.char_code     = ch;
        beat.is_abstract   = field_abs;
        beat.article_index = done_cnt[2:0];
        beat.article_count = count;
        return beat;
    endfunction

    task automatic start_field();
        value_len      = '0;
        at_value_start = 1'b1;
        gap_pending    = 1'b0;
    endtask

    task automatic reset_parser();
        stage         = STG_KEY;
        in_abstract   = 1'b0;
        halted        = 1'b0;
        key_pos       = '0;
        articles_seen = '0;
        start_field();
    endtask

    // all result beats one accepted byte causes
    task automatic predict_extract(input in_beat_t beat);
        logic [7:0]  b;
        logic [3:0]  klen;
        logic [3:0]  pos;
        int          limit;
        bit          chars_out;
        char_class_t cls;
        out_beat_t   step_q[$];
        b = beat.in_byte;
        chars_out = 1'b0;
        if (!halted)
        begin
            case (stage)
                STG_KEY:
                begin
                    klen = in_abstract ? ABSTRACT_KEY_LEN : TITLE_KEY_LEN;
                    pos = (key_pos >= klen) ? 4'd0 : key_pos;
                    if (b == key_byte(in_abstract, pos))
                        pos = pos + 4'd1;
                    else
                        pos = (b == CH_QUOTE) ? 4'd1 : 4'd0;
                    if (pos == klen)
                    begin
                        pos = '0;
                        stage = STG_COLON;
                    end
                    key_pos = pos;
                end
                STG_COLON:
                begin
                    if (b == CH_COLON)
                        stage = STG_SKIP;
                end
                default:
                begin
                    if (stage == STG_COPY && b == CH_QUOTE)
                    begin
                        // field closes, its quote may open the next key
                        step_q.push_back(make_beat(KIND_DONE, 8'h00, in_abstract,
                                                   articles_seen, 4'd0));
                        start_field();
                        key_pos = 4'd1;
                        stage = STG_KEY;
                        if (!in_abstract)
                            in_abstract = 1'b1;
                        else
                        begin
                            if (articles_seen < ARTICLE_CAP)
                                articles_seen = articles_seen + 4'd1;
                            in_abstract = 1'b0;
                            halted = (articles_seen >= ARTICLE_CAP);
                        end
                    end
                    else if (!(stage == STG_SKIP && (b == CH_SPACE || b == CH_QUOTE)))
                    begin
                        limit = in_abstract ? ABSTRACT_BYTES : TITLE_BYTES;
                        stage = STG_COPY;
                        if (value_len + 1 < limit)
                        begin
                            value_len = value_len + 9'd1;
                            if (!(at_value_start && b == CH_SPACE))
                            begin
                                at_value_start = 1'b0;
                                cls = classify(b);
                                if (cls == CLS_WORD)
                                begin
                                    if (gap_pending)
                                        step_q.push_back(make_beat(KIND_CHAR, CH_SPACE,
                                                         in_abstract, articles_seen, 4'd0));
                                    step_q.push_back(make_beat(KIND_CHAR, b, in_abstract,
                                                               articles_seen, 4'd0));
                                    gap_pending = 1'b0;
                                    chars_out = 1'b1;
                                end
                                else if (cls == CLS_BLANK)
                                    gap_pending = 1'b1;
                            end
                        end
                    end
                end
            endcase
        end

        // end of buffer: abort an open field, then the summary
        if (beat.end_of_buffer)
        begin
            if (!halted && (in_abstract || stage != STG_KEY))
            begin
                if (chars_out)
                    step_q.delete();
                step_q.push_back(make_beat(KIND_ABORT, 8'h00, in_abstract,
                                           articles_seen, 4'd0));
            end
            step_q.push_back(make_beat(KIND_SUMMARY, 8'h00, 1'b0, 4'd0, articles_seen));
            reset_parser();
        end

        if (step_q.size() != 0)
        begin
            step_q[step_q.size() - 1].last_of_run = 1'b1;
            foreach (step_q[i])
                expected_beats.push_back(step_q[i]);
        end
    endtask

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    function automatic string fmt_beat(input out_beat_t beat);
        return $sformatf("kind=%0d ch=%02h abs=%0d idx=%0d cnt=%0d last=%0d",
                         beat.result_kind, beat.char_code, beat.is_abstract,
                         beat.article_index, beat.article_count, beat.last_of_run);
    endfunction

    task automatic log_failure(input string what, input out_beat_t want, input out_beat_t got);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("[%0t] %s: expected %s, got %s", $time, what,
                     fmt_beat(want), fmt_beat(got));
    endtask

    task automatic check_result(input out_beat_t got);
        out_beat_t want;
        out_beat_t typed_beat;
        int        typed;
        beats_checked++;
        case (got.result_kind)
            KIND_DONE:    fields_done++;
            KIND_ABORT:   fields_aborted++;
            KIND_SUMMARY:
            begin
                buffers_closed++;
                if (got.article_count == ARTICLE_CAP)
                    capped_buffers++;
            end
            default: ;
        endcase

        // table rows carry their article count
        if (got.result_kind == KIND_SUMMARY && typed_summary_counts.size() != 0)
        begin
            typed = typed_summary_counts.pop_front();
            if (typed != NO_TYPED_COUNT && got.article_count != typed)
            begin
                typed_beat = got;
                typed_beat.article_count = 4'(typed);
                log_failure("summary count differs from table", typed_beat, got);
            end
        end

        if (expected_beats.size() == 0)
            log_failure("result beat with nothing expected", '0, got);
        else
        begin
            want = expected_beats.pop_front();
            if (got.result_kind !== want.result_kind || got.char_code !== want.char_code ||
                got.is_abstract !== want.is_abstract ||
                got.article_index !== want.article_index ||
                got.article_count !== want.article_count ||
                got.last_of_run !== want.last_of_run)
                log_failure("result beat mismatch", want, got);
        end
    endtask

    // sample both handshakes on the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                bytes_accepted++;
                predict_extract(in_data);
            end
            if (out_valid && out_ready)
                check_result(out_data);
        end
    end

    // watchdog on cycles without any beat moving
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("[%0t] no beat moved for %0d cycles, %0d results outstanding",
                     $time, STUCK_LIMIT, expected_beats.size());
            $display("json_title_abstract_extractor verification failed");
            $finish;
        end
    end

    // result side stall pattern, changes character after each random hold
    always @(negedge clk)
    begin
        if (rx_hold == 0)
        begin
            rx_mode <= rx_style_t'($urandom_range(0, 3));
            rx_hold <= $urandom_range(40, 300);
        end
        else
            rx_hold <= rx_hold - 1;
        rx_tick <= rx_tick + 8'd1;
        case (rx_mode)
            RX_FREE:  out_ready <= 1'b1;
            RX_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY: out_ready <= ($urandom_range(0, 3) == 0);
            default:  out_ready <= (rx_tick[3:0] >= 4'd9);
        endcase
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    // one byte beat, held until accepted; bursts with random gaps
    task automatic send_beat(input logic [7:0] value, input logic closing);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap = steady_tx ? 0 : $urandom_range(0, 5);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= '{in_byte: value, end_of_buffer: closing};
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic hold_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(negedge clk);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            buffer_bytes.push_back(s[i]);
    endtask

    function automatic logic [7:0] value_char();
        int r;
        logic [7:0] b;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4:
            begin
                r = $urandom_range(0, 61);
                if (r < 10)
                    b = 8'("0" + r);
                else if (r < 36)
                    b = 8'("A" + (r - 10));
                else
                    b = 8'("a" + (r - 36));
            end
            5, 6:
            begin
                case ($urandom_range(0, 3))
                    0:       b = CH_SPACE;
                    1:       b = CH_TAB;
                    2:       b = CH_LF;
                    default: b = CH_CR;
                endcase
            end
            default:
            begin
                // anything but the closing quote
                b = 8'($urandom_range(0, 255));
                if (b == CH_QUOTE)
                    b = 8'hff;
            end
        endcase
        return b;
    endfunction

    // key, noise before the colon, skip run, value and closing quote
    task automatic add_field(input string key_text);
        logic [7:0] b;
        int         len;
        add_text(key_text);
        repeat ($urandom_range(0, 2))
        begin
            b = 8'($urandom_range(0, 255));
            buffer_bytes.push_back((b == CH_COLON) ? CH_SPACE : b);
        end
        buffer_bytes.push_back(CH_COLON);
        repeat ($urandom_range(0, 3))
            buffer_bytes.push_back($urandom_range(0, 1) ? CH_SPACE : CH_QUOTE);
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(120, 300) : $urandom_range(0, 10);
        repeat (len)
            buffer_bytes.push_back(value_char());
        buffer_bytes.push_back(CH_QUOTE);
    endtask

    task automatic add_record();
        int start;
        int cut;
        int pick;
        start = buffer_bytes.size();
        pick = $urandom_range(0, 19);
        if (pick < 17)
        begin
            add_field("\"title\"");
            case ($urandom_range(0, 3))
                0: add_text(",");
                1: add_text(", ");
                default: ;
            endcase
            // sometimes the title's closing quote opens the abstract key
            if ($urandom_range(0, 3) == 0)
                add_text("abstract\"");
            else
                add_field("\"abstract\"");
            if ($urandom_range(0, 3) == 0)
                add_field("\"abstract\"");
            else if (buffer_bytes[buffer_bytes.size() - 1] != CH_QUOTE)
                add_text("\"");
            // cut-off record
            if (pick >= 14)
            begin
                cut = $urandom_range(start + 1, buffer_bytes.size() - 1);
                buffer_bytes = buffer_bytes[0:cut - 1];
            end
        end
        else
            repeat ($urandom_range(1, 16))
                buffer_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic send_buffer();
        logic closing;
        typed_summary_counts.push_back(NO_TYPED_COUNT);
        foreach (buffer_bytes[i])
        begin
            closing = (i == buffer_bytes.size() - 1);
            send_beat(buffer_bytes[i], closing);
        end
    endtask

    initial
    begin
        logic [7:0] b;
        logic       closing;
        int         records;
        bit         paused_mid;

        reset_parser();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (directed_plan[r])
        begin
            for (int k = 0; k < directed_plan[r].reps; k++)
            begin
                for (int i = 0; i < directed_plan[r].text.len(); i++)
                begin
                    b = directed_plan[r].text[i];
                    if (b == ZERO_STAND_IN)
                        b = 8'h00;
                    closing = directed_plan[r].eob && k == directed_plan[r].reps - 1 &&
                              i == directed_plan[r].text.len() - 1;
                    if (closing)
                        typed_summary_counts.push_back(directed_plan[r].want_count);
                    send_beat(b, closing);
                end
            end
        end

        // article cap: nine articles, the last one ignored
        for (int k = 0; k < ARTICLE_CAP + 1; k++)
        begin
            buffer_bytes.delete();
            add_text("\"title\":\"t\",\"abstract\":\"a\"");
            foreach (buffer_bytes[i])
                send_beat(buffer_bytes[i], 1'b0);
        end
        typed_summary_counts.push_back(ARTICLE_CAP);
        send_beat("z", 1'b0);
        send_beat("z", 1'b1);
        hold_until_drained();

        // random buffers of mixed records
        records = 0;
        paused_mid = 1'b0;
        while (records < RANDOM_RECORDS)
        begin
            buffer_bytes.delete();
            steady_tx = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 12))
            begin
                add_record();
                records++;
            end
            send_buffer();
            if (!paused_mid && records >= RANDOM_RECORDS / 2)
            begin
                paused_mid = 1'b1;
                hold_until_drained();
            end
        end

        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_beats.size() != 0)
        begin
            $display("%0d expected result beats never arrived", expected_beats.size());
            fail_count += expected_beats.size();
        end

        $display("covered %0d bytes in %0d buffers (%0d random records), %0d beats checked",
                 bytes_accepted, buffers_closed, records, beats_checked);
        $display("fields closed %0d, aborted %0d, buffers at the article cap %0d",
                 fields_done, fields_aborted, capped_buffers);
        if (fail_count == 0)
            $display("json_title_abstract_extractor verification clean");
        else
            $display("json_title_abstract_extractor verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/jtae_pkg.sv
hw/rtl/jtae_parser.sv
hw/rtl/json_title_abstract_extractor.sv
dv/testbench.sv
